// ===== design/trv_pkg.sv =====
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types and constants for the reduced-round Trivium keystream block.
// ----------------------------------------------------------------------------
`default_nettype none

package trv_pkg;

  localparam int ROUND_COUNT_WIDTH = 12;
  localparam int CFG_W             = 12;
  localparam int CFG_IDX_W         = 2;
  localparam int KEY_W             = 80;

  localparam int LEN_A = 93;
  localparam int LEN_B = 84;
  localparam int LEN_C = 111;

  localparam int TAP_OFFSET = 64;

  localparam logic [CFG_W-1:0] ROUND_RESET = CFG_W'(720);
  localparam logic [CFG_W-1:0] PROBE_RESET = CFG_W'(221);

  typedef logic [ROUND_COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_ROUND = 2'd0,
    CFG_PROBE_STEP   = 2'd1
  } trv_cfg_e;

  typedef struct packed {
    logic [63:0] key_low;
    logic [15:0] key_high;
    logic [63:0] iv_low;
    logic [15:0] iv_high;
  } trv_in_t;

  typedef struct packed {
    logic keystream_bit;
    logic probe_bit;
  } trv_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } trv_cmd_t;

  typedef struct packed {
    logic last_hit;
  } trv_status_t;

endpackage

`default_nettype wire

// ===== design/trivium_round_output_bit.sv =====
// ----------------------------------------------------------------------------
// trivium_round_output_bit
// Reduced-round Trivium: keystream bit of a chosen round plus a B-register probe.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one 80-bit key and one
//   80-bit IV. On transfer the 288-bit state is loaded and one update step
//   runs per clock. Output channel (out_valid_o/out_ready_i) returns the
//   keystream bit of output_round and the B bit made at probe_step.
//   With s = output_round - 64 (or output_round when it is 64 or below),
//   an item runs update steps on the single update unit until the step
//   counter reaches max(s, probe_step); the result is then registered, and
//   the next item is taken once that result has gone to the output register.
//   One item is in work at a time. A finished result sits in the output
//   register while the next item runs; if the receiver stalls past that,
//   the sequencer holds the new result and takes no further input.
//   Settings are written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user
//   only while idle; the block itself does not enforce it. Reset restores
//   output_round 720 and probe_step 221 and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trivium_round_output_bit
  import trv_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [CFG_W-1:0]     cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  trv_in_t             in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output trv_out_t            out_data_o
);

  trv_cmd_t    cmd;
  trv_status_t status;

  trv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  trv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/trv_ctrl.sv =====
// ----------------------------------------------------------------------------
// trv_ctrl
// Sequencer: accepts an item, runs the update steps, hands over the result.
// ----------------------------------------------------------------------------
`default_nettype none

module trv_ctrl
  import trv_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  input  trv_status_t status_i,
  output trv_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.last_hit) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/trv_dp.sv =====
// ----------------------------------------------------------------------------
// trv_dp
// Datapath: settings, 288-bit state, step counter, capture and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trv_dp
  import trv_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  input  trv_in_t              in_data_i,
  input  trv_cmd_t             cmd_i,
  output trv_status_t          status_o,
  output trv_out_t             out_data_o
);

  logic [CFG_W-1:0] round_q, probe_q;

  logic [LEN_A-1:0] a_q, a_d;
  logic [LEN_B-1:0] b_q, b_d;
  logic [LEN_C-1:0] c_q, c_d;
  cnt_t             cnt_q, cnt_d;
  cnt_t             cap_q, pstep_q, last_q;
  logic             hi_q;
  logic             z_q, pr_q;
  trv_out_t         out_q;

  logic [KEY_W-1:0] key, iv;
  logic             hi_n;
  cnt_t             cap_n, last_n;
  logic             na, nb, nc, tap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= ROUND_RESET;
      probe_q <= PROBE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OUTPUT_ROUND: round_q <= cfg_data_i;
        CFG_PROBE_STEP:   probe_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key    = {in_data_i.key_high, in_data_i.key_low};
  assign iv     = {in_data_i.iv_high, in_data_i.iv_low};
  assign hi_n   = (round_q > CFG_W'(TAP_OFFSET));
  assign cap_n  = hi_n ? cnt_t'(round_q - CFG_W'(TAP_OFFSET)) : cnt_t'(round_q);
  assign last_n = (cap_n > cnt_t'(probe_q)) ? cap_n : cnt_t'(probe_q);

  assign na = c_q[45] ^ (c_q[1] & c_q[2]) ^ c_q[0] ^ a_q[24];
  assign nb = a_q[27] ^ (a_q[1] & a_q[2]) ^ a_q[0] ^ b_q[6];
  assign nc = b_q[15] ^ (b_q[1] & b_q[2]) ^ b_q[0] ^ c_q[24];

  assign tap = hi_q
    ? (a_q[TAP_OFFSET+28] ^ a_q[TAP_OFFSET+1] ^ b_q[TAP_OFFSET+16] ^
       b_q[TAP_OFFSET+1] ^ c_q[TAP_OFFSET+46] ^ c_q[TAP_OFFSET+1])
    : (a_q[28] ^ a_q[1] ^ b_q[16] ^ b_q[1] ^ c_q[46] ^ c_q[1]);

  assign status_o.last_hit = (cnt_q == last_q);

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    c_d   = c_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      a_d = '0;
      b_d = '0;
      c_d = '0;
      for (int i = 0; i < KEY_W; i++) begin
        a_d[LEN_A-1-i] = key[i];
        b_d[LEN_B-1-i] = iv[i];
      end
      c_d[2:0] = 3'b111;
      cnt_d    = '0;
    end else if (cmd_i.step && !status_o.last_hit) begin
      a_d   = {na, a_q[LEN_A-1:1]};
      b_d   = {nb, b_q[LEN_B-1:1]};
      c_d   = {nc, c_q[LEN_C-1:1]};
      cnt_d = cnt_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    if (cmd_i.load) begin
      hi_q    <= hi_n;
      cap_q   <= cap_n;
      pstep_q <= cnt_t'(probe_q);
      last_q  <= last_n;
    end
    if (cmd_i.step && cnt_q == cap_q) begin
      z_q <= tap;
    end
    if (cmd_i.step && cnt_q == pstep_q) begin
      pr_q <= b_q[LEN_B-1];
    end
    if (cmd_i.push) begin
      out_q.keystream_bit <= z_q;
      out_q.probe_bit     <= pr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== design/trv_checker.sv =====
// ----------------------------------------------------------------------------
// trv_checker
// Port-level checks on the transfer sequencing of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trv_checker
  import trv_pkg::*;
(
  input wire      clk_i,
  input wire      rst_ni,
  input wire      in_valid_i,
  input wire      in_ready_o,
  input wire      out_valid_o,
  input wire      out_ready_i,
  input trv_out_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken while an item is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result presented while still busy");

endmodule

bind trivium_round_output_bit trv_checker u_trv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
